[design/block_aligned_shelf_atlas_packer_macros.svh]
// Assertion macros for the shelf atlas packer checker.
// Included by the checker file only; needs no other file.
`ifndef BLOCK_ALIGNED_SHELF_ATLAS_PACKER_MACROS_SVH
`define BLOCK_ALIGNED_SHELF_ATLAS_PACKER_MACROS_SVH

// Property checked while out of reset.
`define BSAP_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// Property checked at every edge, reset included.
`define BSAP_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

[design/bsap_pkg.sv]
// Shared types, constants and codes of the shelf atlas packer.
// No dependencies; used by every module of the block.
package bsap_pkg;

  localparam int NUM_CLASSES = 3;
  localparam int MAX_DIM     = 16384;
  localparam int PAGE_BITS   = 16;
  localparam int CFG_CLASSES = 3;

  localparam int DIM_W   = 15;
  localparam int POS_W   = 14;
  localparam int PAGE_W  = 16;
  localparam int BLK_W   = 4;
  localparam int CLS_W   = 2;
  localparam int STAT_W  = 3;
  localparam int CFG_IDX_W = 4;

  // Cursor arrays only need the classes that can actually be valid.
  localparam int EFF_CLASSES = (NUM_CLASSES < CFG_CLASSES) ? NUM_CLASSES : CFG_CLASSES;
  localparam int CUR_IDX_W   = (EFF_CLASSES > 1) ? $clog2(EFF_CLASSES) : 1;

  localparam int DIV_STEPS = DIM_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [16:0] MAX_DIM_V = 17'(MAX_DIM);

  localparam logic [STAT_W-1:0] STAT_PLACED      = 3'd0;
  localparam logic [STAT_W-1:0] STAT_ATLAS_ZERO  = 3'd1;
  localparam logic [STAT_W-1:0] STAT_INVALID     = 3'd2;
  localparam logic [STAT_W-1:0] STAT_TOO_BIG     = 3'd3;
  localparam logic [STAT_W-1:0] STAT_ALIGNED_BIG = 3'd4;
  localparam logic [STAT_W-1:0] STAT_UNPLACEABLE = 3'd5;
  localparam logic [STAT_W-1:0] STAT_SKIPPED     = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_W = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_H = 4'd1;
  localparam int CFG_BLK_BASE = 2;

  localparam logic [DIM_W-1:0] ATLAS_W_RST = 15'd4096;
  localparam logic [DIM_W-1:0] ATLAS_H_RST = 15'd4096;
  localparam logic [BLK_W-1:0] BLK_W_RST [CFG_CLASSES] = '{4'd4, 4'd6, 4'd8};
  localparam logic [BLK_W-1:0] BLK_H_RST [CFG_CLASSES] = '{4'd4, 4'd6, 4'd8};

  typedef struct packed {
    logic             batch_start;
    logic [CLS_W-1:0] footprint_class;
    logic [DIM_W-1:0] rect_width;
    logic [DIM_W-1:0] rect_height;
    logic             name_present;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [PAGE_W-1:0] page_index;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic check;
    logic div_step;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic early_err;
    logic div_last;
    logic out_free;
  } dp_stat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_PLACE
  } state_t;

endpackage

[design/block_aligned_shelf_atlas_packer.sv]
// Top level of the block-aligned shelf atlas packer.
// Joins bsap_ctrl and bsap_dp; types from bsap_pkg.
//
//  channel   direction  handshake            word
//  in_       input      in_valid / in_ready  bsap_pkg::in_item_t
//  out_      output     out_valid/out_ready  bsap_pkg::out_item_t
//  cfg_      input      cfg_we only          cfg_index, cfg_wdata
//
// One item at a time: an item that passes the early checks goes through accept,
// check, 15 restoring remainder steps and place; an item that fails an early
// check skips the remainder steps and goes from check straight to place. The
// serial remainder units set the time per item.
// A stalled result holds in the output register; the next item is accepted
// meanwhile and waits in its place step. Reset (rst_n low, synchronous) restores
// the register defaults and clears every cursor at once.
module block_aligned_shelf_atlas_packer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bsap_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bsap_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [bsap_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bsap_pkg::DIM_W-1:0]     cfg_wdata
);

  bsap_pkg::ctrl_cmd_t cmd;
  bsap_pkg::dp_stat_t  stat;

  bsap_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bsap_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

endmodule

[design/bsap_ctrl.sv]
// Sequencer of the shelf atlas packer: accept, check, divide, place.
// Depends on bsap_pkg; drives the datapath through ctrl_cmd_t.
module bsap_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bsap_pkg::dp_stat_t  stat,
  output bsap_pkg::ctrl_cmd_t cmd
);

  bsap_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bsap_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      bsap_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = bsap_pkg::S_CHECK;
        end
      end
      bsap_pkg::S_CHECK: begin
        cmd.check = 1'b1;
        // errors found up front need no rounding
        state_nxt = stat.early_err ? bsap_pkg::S_PLACE : bsap_pkg::S_DIV;
      end
      bsap_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = bsap_pkg::S_PLACE;
        end
      end
      bsap_pkg::S_PLACE: begin
        // hold until the output register can take the word
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = bsap_pkg::S_IDLE;
        end
      end
      default: state_nxt = bsap_pkg::S_IDLE;
    endcase
  end

endmodule

[design/bsap_dp.sv]
// Datapath of the shelf atlas packer: config registers, shelf cursors,
// serial remainder units for block rounding, output register. Uses bsap_pkg.
module bsap_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  bsap_pkg::ctrl_cmd_t                  cmd,
  output bsap_pkg::dp_stat_t                   stat,
  input  bsap_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output bsap_pkg::out_item_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [bsap_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bsap_pkg::DIM_W-1:0]           cfg_wdata
);

  localparam int DW = bsap_pkg::DIM_W;
  localparam int BW = bsap_pkg::BLK_W;
  localparam int NC = bsap_pkg::EFF_CLASSES;
  localparam int CUR_IDX_W_L = bsap_pkg::CUR_IDX_W;

  // configuration
  logic [DW-1:0] atlas_w_r, atlas_h_r;
  logic [BW-1:0] blk_w_r [bsap_pkg::CFG_CLASSES];
  logic [BW-1:0] blk_h_r [bsap_pkg::CFG_CLASSES];

  // per-class cursors
  logic [bsap_pkg::PAGE_BITS-1:0] cur_pg_r [NC];
  logic [DW-1:0] cur_x_r [NC];
  logic [DW-1:0] cur_y_r [NC];
  logic [DW-1:0] cur_sh_r [NC];
  logic          failed_r;

  // item and rounding state
  bsap_pkg::in_item_t          item_r;
  logic [bsap_pkg::STAT_W-1:0] err_r;
  logic [DW-1:0]               sum_w_r, sum_h_r, dvd_w_r, dvd_h_r;
  logic [BW-1:0]               rem_w_r, rem_h_r;
  logic [bsap_pkg::CNT_W-1:0]  cnt_r;

  logic                out_valid_r;
  bsap_pkg::out_item_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atlas_w_r <= bsap_pkg::ATLAS_W_RST;
      atlas_h_r <= bsap_pkg::ATLAS_H_RST;
      for (int c = 0; c < bsap_pkg::CFG_CLASSES; c++) begin
        blk_w_r[c] <= bsap_pkg::BLK_W_RST[c];
        blk_h_r[c] <= bsap_pkg::BLK_H_RST[c];
      end
    end else if (cfg_we) begin
      if (cfg_index == bsap_pkg::CFG_ATLAS_W) begin
        atlas_w_r <= cfg_wdata;
      end else if (cfg_index == bsap_pkg::CFG_ATLAS_H) begin
        atlas_h_r <= cfg_wdata;
      end
      for (int c = 0; c < bsap_pkg::CFG_CLASSES; c++) begin
        if (cfg_index == bsap_pkg::CFG_IDX_W'(bsap_pkg::CFG_BLK_BASE + 2 * c)) begin
          blk_w_r[c] <= cfg_wdata[BW-1:0];
        end
        if (cfg_index == bsap_pkg::CFG_IDX_W'(bsap_pkg::CFG_BLK_BASE + 2 * c + 1)) begin
          blk_h_r[c] <= cfg_wdata[BW-1:0];
        end
      end
    end
  end

  // clamp page size
  logic [DW-1:0] big_w, big_h;
  assign big_w = ({2'b00, atlas_w_r} > bsap_pkg::MAX_DIM_V) ?
                 bsap_pkg::MAX_DIM_V[DW-1:0] : atlas_w_r;
  assign big_h = ({2'b00, atlas_h_r} > bsap_pkg::MAX_DIM_V) ?
                 bsap_pkg::MAX_DIM_V[DW-1:0] : atlas_h_r;

  // early checks on the held item
  logic                        cls_ok;
  logic [BW-1:0]               bw, bh;
  logic [bsap_pkg::STAT_W-1:0] early;
  logic [CUR_IDX_W_L-1:0]      ci;

  assign cls_ok = (32'(item_r.footprint_class) < bsap_pkg::NUM_CLASSES) &&
                  (32'(item_r.footprint_class) < bsap_pkg::CFG_CLASSES);
  assign bw = cls_ok ? blk_w_r[item_r.footprint_class] : '0;
  assign bh = cls_ok ? blk_h_r[item_r.footprint_class] : '0;
  assign ci = item_r.footprint_class[CUR_IDX_W_L-1:0];

  always_comb begin
    if (failed_r) begin
      early = bsap_pkg::STAT_SKIPPED;
    end else if (big_w == '0 || big_h == '0) begin
      early = bsap_pkg::STAT_ATLAS_ZERO;
    end else if (!cls_ok || !item_r.name_present || item_r.rect_width == '0 ||
                 item_r.rect_height == '0 || bw == '0 || bh == '0) begin
      early = bsap_pkg::STAT_INVALID;
    end else if (item_r.rect_width > big_w || item_r.rect_height > big_h) begin
      early = bsap_pkg::STAT_TOO_BIG;
    end else begin
      early = bsap_pkg::STAT_PLACED;
    end
  end

  // one restoring step per cycle on both dimensions
  logic [BW:0] tw, th;
  assign tw = {rem_w_r, dvd_w_r[DW-1]};
  assign th = {rem_h_r, dvd_h_r[DW-1]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.check) begin
      err_r   <= early;
      sum_w_r <= DW'({1'b0, item_r.rect_width} + 16'(bw) - 16'd1);
      sum_h_r <= DW'({1'b0, item_r.rect_height} + 16'(bh) - 16'd1);
      dvd_w_r <= DW'({1'b0, item_r.rect_width} + 16'(bw) - 16'd1);
      dvd_h_r <= DW'({1'b0, item_r.rect_height} + 16'(bh) - 16'd1);
      rem_w_r <= '0;
      rem_h_r <= '0;
      cnt_r   <= '0;
    end else if (cmd.div_step) begin
      dvd_w_r <= {dvd_w_r[DW-2:0], 1'b0};
      dvd_h_r <= {dvd_h_r[DW-2:0], 1'b0};
      rem_w_r <= (tw >= {1'b0, bw}) ? BW'(tw - {1'b0, bw}) : tw[BW-1:0];
      rem_h_r <= (th >= {1'b0, bh}) ? BW'(th - {1'b0, bh}) : th[BW-1:0];
      cnt_r   <= cnt_r + 1'b1;
    end
  end

  // placement
  logic [DW-1:0] aw, ah;
  logic [DW-1:0] x0, y0, sh0, x1, y1, sh1, x2, y2, sh2;
  logic [bsap_pkg::PAGE_BITS-1:0] pg0, pg2;
  logic wrap, newpage;
  logic [bsap_pkg::STAT_W-1:0] final_st;

  assign aw  = sum_w_r - DW'(rem_w_r);
  assign ah  = sum_h_r - DW'(rem_h_r);
  assign x0  = cur_x_r[ci];
  assign y0  = cur_y_r[ci];
  assign sh0 = cur_sh_r[ci];
  assign pg0 = cur_pg_r[ci];

  assign wrap    = ({1'b0, x0} + {1'b0, aw}) > {1'b0, big_w};
  assign x1      = wrap ? '0 : x0;
  assign y1      = wrap ? DW'({1'b0, y0} + {1'b0, sh0}) : y0;
  assign sh1     = wrap ? '0 : sh0;
  assign newpage = ({1'b0, y1} + {1'b0, ah}) > {1'b0, big_h};
  assign pg2     = newpage ? pg0 + 1'b1 : pg0;
  assign x2      = newpage ? '0 : x1;
  assign y2      = newpage ? '0 : y1;
  assign sh2     = newpage ? '0 : sh1;

  always_comb begin
    if (err_r != bsap_pkg::STAT_PLACED) begin
      final_st = err_r;
    end else if (aw > big_w || ah > big_h) begin
      final_st = bsap_pkg::STAT_ALIGNED_BIG;
    end else if (newpage && pg0 == '1) begin
      final_st = bsap_pkg::STAT_UNPLACEABLE;
    end else begin
      final_st = bsap_pkg::STAT_PLACED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      failed_r <= 1'b0;
      for (int c = 0; c < NC; c++) begin
        cur_pg_r[c] <= '0;
        cur_x_r[c]  <= '0;
        cur_y_r[c]  <= '0;
        cur_sh_r[c] <= '0;
      end
    end else if (cmd.load && in_data.batch_start) begin
      failed_r <= 1'b0;
      for (int c = 0; c < NC; c++) begin
        cur_pg_r[c] <= '0;
        cur_x_r[c]  <= '0;
        cur_y_r[c]  <= '0;
        cur_sh_r[c] <= '0;
      end
    end else if (cmd.commit) begin
      if (final_st != bsap_pkg::STAT_PLACED && final_st != bsap_pkg::STAT_SKIPPED) begin
        failed_r <= 1'b1;
      end
      if (final_st == bsap_pkg::STAT_PLACED) begin
        cur_pg_r[ci] <= pg2;
        cur_x_r[ci]  <= DW'({1'b0, x2} + {1'b0, aw});
        cur_y_r[ci]  <= y2;
        cur_sh_r[ci] <= (ah > sh2) ? ah : sh2;
      end else if (final_st == bsap_pkg::STAT_UNPLACEABLE) begin
        // the shelf wrap stays even though the page ran out
        cur_x_r[ci]  <= x1;
        cur_y_r[ci]  <= y1;
        cur_sh_r[ci] <= sh1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r.status <= final_st;
      if (final_st == bsap_pkg::STAT_PLACED) begin
        out_r.page_index <= bsap_pkg::PAGE_W'(pg2);
        out_r.pos_x      <= x2[bsap_pkg::POS_W-1:0];
        out_r.pos_y      <= y2[bsap_pkg::POS_W-1:0];
      end else begin
        out_r.page_index <= '0;
        out_r.pos_x      <= '0;
        out_r.pos_y      <= '0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data       = out_r;
  assign stat.early_err = (early != bsap_pkg::STAT_PLACED);
  assign stat.div_last  = (cnt_r == bsap_pkg::CNT_W'(bsap_pkg::DIV_STEPS - 1));
  assign stat.out_free  = !out_valid_r || out_ready;

endmodule

[design/bsap_checker.sv]
// Port-level checks of the shelf atlas packer, bound to the top level.
// Uses bsap_pkg and the macros header.
`include "block_aligned_shelf_atlas_packer_macros.svh"

module bsap_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input bsap_pkg::out_item_t out_data
);

  `BSAP_ASSERT_ALWAYS(a_rst_out, clk, !rst_n |=> !out_valid, "out_valid after reset")
  `BSAP_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "result word changed while stalled")
  `BSAP_ASSERT(a_one_item, clk, rst_n, in_valid && in_ready |=> !in_ready, "second word taken while busy")
  `BSAP_ASSERT(a_err_zero, clk, rst_n, out_valid && out_data.status != bsap_pkg::STAT_PLACED |-> out_data.page_index == '0 && out_data.pos_x == '0 && out_data.pos_y == '0, "error word carries a position")
  `BSAP_ASSERT(a_stat_code, clk, rst_n, out_valid |-> out_data.status <= bsap_pkg::STAT_SKIPPED, "status code out of range")

endmodule

bind block_aligned_shelf_atlas_packer bsap_checker u_bsap_checker (.*);

[dv/bsap_placement_checker.sv]
// Placement scoreboard for the shelf atlas packer: mirrors the register file,
// predicts every placement word and checks the result channel in order.
// Depends on bsap_pkg for the word types, limits, register indexes and status codes.
module bsap_placement_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  bsap_pkg::in_item_t             in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  bsap_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [bsap_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bsap_pkg::DIM_W-1:0]     cfg_wdata,
  output int                             mismatches,
  output int                             pending
);
  import bsap_pkg::*;

  localparam int REPORT_LIMIT = 10;
  localparam int CFG_REGS = CFG_BLK_BASE + 2 * CFG_CLASSES;
  localparam logic [PAGE_W-1:0] PAGE_LAST = '1;

  int unsigned atlas_w;
  int unsigned atlas_h;
  int unsigned blk_w [CFG_CLASSES];
  int unsigned blk_h [CFG_CLASSES];

  logic [PAGE_W-1:0] cur_page [NUM_CLASSES];
  int unsigned cur_x [NUM_CLASSES];
  int unsigned cur_y [NUM_CLASSES];
  int unsigned shelf_h [NUM_CLASSES];
  bit batch_failed;

  out_item_t placement_q [$];
  int fail_cnt;

  function automatic void clear_cursors();
    for (int c = 0; c < NUM_CLASSES; c++) begin
      cur_page[c] = '0;
      cur_x[c] = 0;
      cur_y[c] = 0;
      shelf_h[c] = 0;
    end
    batch_failed = 1'b0;
  endfunction

  function automatic void write_cfg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    int c;
    if (idx == CFG_ATLAS_W) begin
      atlas_w = val;
    end else if (idx == CFG_ATLAS_H) begin
      atlas_h = val;
    end else if (idx < CFG_REGS) begin
      c = (int'(idx) - CFG_BLK_BASE) / 2;
      if (idx[0] == 1'b0) begin
        blk_w[c] = val[BLK_W-1:0];
      end else begin
        blk_h[c] = val[BLK_W-1:0];
      end
    end
    // indexes past the block sizes hit nothing
  endfunction

  // Advance the cursor of the word's class and return the placement it gets.
  function automatic out_item_t place_rect(in_item_t w);
    out_item_t r;
    int unsigned lim_w, lim_h, bw, bh, rw, rh, aw, ah;
    int c;
    r = '0;
    r.status = STAT_PLACED;
    lim_w = (atlas_w > MAX_DIM) ? MAX_DIM : atlas_w;
    lim_h = (atlas_h > MAX_DIM) ? MAX_DIM : atlas_h;
    c = w.footprint_class;
    rw = w.rect_width;
    rh = w.rect_height;
    if (w.batch_start) begin
      clear_cursors();
    end
    if (batch_failed) begin
      r.status = STAT_SKIPPED;
      return r;
    end
    if (lim_w == 0 || lim_h == 0) begin
      r.status = STAT_ATLAS_ZERO;
    end else if (c >= NUM_CLASSES || c >= CFG_CLASSES) begin
      r.status = STAT_INVALID;
    end else begin
      bw = blk_w[c];
      bh = blk_h[c];
      if (!w.name_present || rw == 0 || rh == 0 || bw == 0 || bh == 0) begin
        r.status = STAT_INVALID;
      end else if (rw > lim_w || rh > lim_h) begin
        r.status = STAT_TOO_BIG;
      end else begin
        aw = ((rw + bw - 1) / bw) * bw;
        ah = ((rh + bh - 1) / bh) * bh;
        if (aw > lim_w || ah > lim_h) begin
          r.status = STAT_ALIGNED_BIG;
        end else begin
          // row full: open a new shelf below the tallest item of this one
          if (cur_x[c] + aw > lim_w) begin
            cur_x[c] = 0;
            cur_y[c] += shelf_h[c];
            shelf_h[c] = 0;
          end
          if (cur_y[c] + ah > lim_h) begin
            if (cur_page[c] == PAGE_LAST) begin
              r.status = STAT_UNPLACEABLE;
            end else begin
              cur_page[c]++;
              cur_x[c] = 0;
              cur_y[c] = 0;
              shelf_h[c] = 0;
            end
          end
          if (r.status == STAT_PLACED && (cur_x[c] + aw > lim_w || cur_y[c] + ah > lim_h)) begin
            r.status = STAT_UNPLACEABLE;
          end
          if (r.status == STAT_PLACED) begin
            r.page_index = cur_page[c];
            r.pos_x = POS_W'(cur_x[c]);
            r.pos_y = POS_W'(cur_y[c]);
            cur_x[c] += aw;
            if (ah > shelf_h[c]) begin
              shelf_h[c] = ah;
            end
          end
        end
      end
    end
    if (r.status != STAT_PLACED) begin
      batch_failed = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t exp_w;
    if (!rst_n) begin
      atlas_w = ATLAS_W_RST;
      atlas_h = ATLAS_H_RST;
      for (int c = 0; c < CFG_CLASSES; c++) begin
        blk_w[c] = BLK_W_RST[c];
        blk_h[c] = BLK_H_RST[c];
      end
      clear_cursors();
      placement_q.delete();
      fail_cnt = 0;
    end else begin
      if (cfg_we) begin
        write_cfg(cfg_index, cfg_wdata);
      end
      if (in_valid && in_ready) begin
        placement_q = {placement_q, place_rect(in_data)};
      end
      if (out_valid && out_ready) begin
        if (placement_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_LIMIT) begin
            $display("unexpected placement word: status %0d page %0d x %0d y %0d",
                     out_data.status, out_data.page_index, out_data.pos_x, out_data.pos_y);
          end
        end else begin
          exp_w = placement_q.pop_front();
          if (out_data.status !== exp_w.status || out_data.page_index !== exp_w.page_index ||
              out_data.pos_x !== exp_w.pos_x || out_data.pos_y !== exp_w.pos_y) begin
            fail_cnt++;
            if (fail_cnt <= REPORT_LIMIT) begin
              $display("placement mismatch: expected status %0d page %0d x %0d y %0d, got status %0d page %0d x %0d y %0d",
                       exp_w.status, exp_w.page_index, exp_w.pos_x, exp_w.pos_y,
                       out_data.status, out_data.page_index, out_data.pos_x, out_data.pos_y);
            end
          end
        end
      end
    end
    mismatches <= fail_cnt;
    pending <= placement_q.size();
  end

endmodule

[dv/tb_block_aligned_shelf_atlas_packer.sv]
// Testbench top for the shelf atlas packer: clock, reset, register writes,
// rectangle stimulus and result-side stalls. Needs bsap_pkg, the packer RTL
// and bsap_placement_checker, which predicts and compares every word.
module tb_block_aligned_shelf_atlas_packer;
  import bsap_pkg::*;

  localparam int HALF_PERIOD = 4;
  localparam int RESET_CYCLES = 6;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES = 24;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 100;
  localparam int BLK_MAX = 12;
  localparam int DIM_LIMIT = (1 << DIM_W) - 1;
  localparam int PAGE_RUN = 16;
  localparam logic [CLS_W-1:0] BAD_CLASS = 2'd3;
  localparam int CFG_UNMAPPED_LO = CFG_BLK_BASE + 2 * CFG_CLASSES;
  localparam int CFG_UNMAPPED_HI = (1 << CFG_IDX_W) - 1;

  typedef logic [CFG_CLASSES-1:0][BLK_W-1:0] blk_set_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0] cfg_wdata = '0;

  int mismatches;
  int pending;
  bit gaps_on = 1'b1;
  bit hold_off_req = 1'b0;
  int unsigned lim_w = ATLAS_W_RST;
  int unsigned lim_h = ATLAS_H_RST;
  int unsigned stall_cnt = 0;

  always #HALF_PERIOD clk = ~clk;

  block_aligned_shelf_atlas_packer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  bsap_placement_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  function automatic in_item_t rect(bit bs, logic [CLS_W-1:0] cls, int unsigned w,
                                    int unsigned h, bit np);
    in_item_t r;
    r.batch_start = bs;
    r.footprint_class = cls;
    r.rect_width = DIM_W'(w);
    r.rect_height = DIM_W'(h);
    r.name_present = np;
    return r;
  endfunction

  function automatic int unsigned pick_dim();
    case ($urandom_range(0, 9))
      0: return $urandom_range(1, 16);
      1, 2: return $urandom_range(17, 512);
      3, 4: return $urandom_range(513, 4096);
      5: return MAX_DIM;
      6: return $urandom_range(MAX_DIM + 1, DIM_LIMIT);
      7: return DIM_LIMIT;
      default: return $urandom_range(1, MAX_DIM);
    endcase
  endfunction

  function automatic logic [BLK_W-1:0] pick_block();
    if ($urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        return '0;
      end
      return BLK_W'($urandom_range(BLK_MAX + 1, (1 << BLK_W) - 1));
    end
    return BLK_W'($urandom_range(1, BLK_MAX));
  endfunction

  // Mostly small extents so that shelves and pages fill up.
  function automatic int unsigned pick_extent(int unsigned lim);
    int unsigned hi;
    hi = lim >> $urandom_range(0, 6);
    if (hi == 0) begin
      hi = 1;
    end
    return $urandom_range(1, hi);
  endfunction

  function automatic in_item_t rand_rect();
    in_item_t r;
    int unsigned kind;
    kind = $urandom_range(0, 39);
    r = rect($urandom_range(0, 9) == 0, CLS_W'($urandom_range(0, NUM_CLASSES - 1)),
             pick_extent(lim_w), pick_extent(lim_h), 1'b1);
    if (kind == 0) begin
      r.footprint_class = CLS_W'($urandom_range(0, (1 << CLS_W) - 1));
      r.rect_width = DIM_W'($urandom_range(0, DIM_LIMIT));
      r.rect_height = DIM_W'($urandom_range(0, DIM_LIMIT));
      r.name_present = 1'($urandom_range(0, 1));
    end else if (kind == 1) begin
      case ($urandom_range(0, 4))
        0: r.footprint_class = BAD_CLASS;
        1: r.name_present = 1'b0;
        2: r.rect_width = '0;
        3: r.rect_height = '0;
        default: r.rect_width = DIM_W'(lim_w + 1);
      endcase
    end
    return r;
  endfunction

  task automatic write_reg(int idx, logic [DIM_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Block sets are packed with class 0 in the low nibble.
  task automatic load_atlas(int unsigned aw, int unsigned ah, blk_set_t bw, blk_set_t bh);
    write_reg(CFG_ATLAS_W, DIM_W'(aw));
    write_reg(CFG_ATLAS_H, DIM_W'(ah));
    for (int c = 0; c < CFG_CLASSES; c++) begin
      write_reg(CFG_BLK_BASE + 2 * c, {(DIM_W - BLK_W)'($urandom()), bw[c]});
      write_reg(CFG_BLK_BASE + 2 * c + 1, {(DIM_W - BLK_W)'($urandom()), bh[c]});
    end
    // a write past the block sizes must leave every register alone
    write_reg($urandom_range(CFG_UNMAPPED_LO, CFG_UNMAPPED_HI), DIM_W'($urandom()));
    cfg_we <= 1'b0;
    lim_w = (aw > MAX_DIM) ? MAX_DIM : aw;
    lim_h = (ah > MAX_DIM) ? MAX_DIM : ah;
  endtask

  task automatic send_rect(in_item_t w);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_placements();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Result side: random stalls, one long hold-off on request.
  initial begin
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (gaps_on && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("block_aligned_shelf_atlas_packer verification failed");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    blk_set_t bw;
    blk_set_t bh;
    int unsigned aw;
    int unsigned ah;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values
    send_rect(rect(1'b1, 2'd0, 1, 1, 1'b1));
    send_rect(rect(1'b0, 2'd0, 5, 3, 1'b1));
    send_rect(rect(1'b0, 2'd1, 4095, 6, 1'b1));   // rounds past the page width
    send_rect(rect(1'b0, 2'd0, 1, 1, 1'b1));      // skipped
    send_rect(rect(1'b1, 2'd2, 4096, 4096, 1'b1));
    send_rect(rect(1'b0, 2'd2, 1, 1, 1'b1));      // next page
    send_rect(rect(1'b0, 2'd2, 4096, 1, 1'b1));   // next shelf
    send_rect(rect(1'b0, BAD_CLASS, 8, 8, 1'b1));
    send_rect(rect(1'b1, 2'd1, 0, 5, 1'b1));
    send_rect(rect(1'b1, 2'd1, 5, 0, 1'b1));
    send_rect(rect(1'b1, 2'd1, 5, 5, 1'b0));
    send_rect(rect(1'b1, 2'd0, 4097, 1, 1'b1));
    send_rect(rect(1'b1, 2'd0, 1, DIM_LIMIT, 1'b1));
    send_rect(rect(1'b1, 2'd1, 7, 5, 1'b1));
    wait_placements();

    load_atlas(0, 4096, {4'd8, 4'd6, 4'd4}, {4'd8, 4'd6, 4'd4});
    send_rect(rect(1'b1, 2'd0, 1, 1, 1'b1));
    send_rect(rect(1'b0, 2'd1, 1, 1, 1'b1));
    wait_placements();
    load_atlas(4096, 0, {4'd8, 4'd6, 4'd4}, {4'd8, 4'd6, 4'd4});
    send_rect(rect(1'b1, 2'd2, 8, 8, 1'b1));
    wait_placements();

    // oversized atlas clamps; class 0 unsupported, class 1 odd blocks
    load_atlas(DIM_LIMIT, DIM_LIMIT, {4'd1, 4'd13, 4'd0}, {4'd1, 4'd15, 4'd4});
    send_rect(rect(1'b1, 2'd0, 4, 4, 1'b1));
    send_rect(rect(1'b1, 2'd2, MAX_DIM, MAX_DIM, 1'b1));
    send_rect(rect(1'b0, 2'd2, 1, 1, 1'b1));
    send_rect(rect(1'b0, 2'd2, MAX_DIM + 1, 1, 1'b1));
    send_rect(rect(1'b1, 2'd1, MAX_DIM, 1, 1'b1));
    send_rect(rect(1'b1, 2'd1, 13, 15, 1'b1));
    wait_placements();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      for (int c = 0; c < CFG_CLASSES; c++) begin
        bw[c] = (p == 0) ? BLK_W'(1) : (p == 1) ? BLK_W'(BLK_MAX) : pick_block();
        bh[c] = (p == 0) ? BLK_W'(1) : (p == 1) ? BLK_W'(BLK_MAX) : pick_block();
      end
      aw = (p == 0) ? $urandom_range(1, 16) : (p == 1) ? MAX_DIM : (p == 2) ? DIM_LIMIT : pick_dim();
      ah = (p == 0) ? $urandom_range(1, 16) : (p == 1) ? MAX_DIM : (p == 2) ? DIM_LIMIT : pick_dim();
      load_atlas(aw, ah, bw, bh);
      // no idling in the closing phase
      gaps_on = (p < RANDOM_PHASES - 1);
      if (p == 3) begin
        hold_off_req = 1'b1;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_rect(rand_rect());
      end
      wait_placements();
    end

    // 1x1 pages: every placement after the first of a batch opens a new page
    gaps_on = 1'b0;
    load_atlas(1, 1, {4'd1, 4'd1, 4'd1}, {4'd1, 4'd1, 4'd1});
    send_rect(rect(1'b1, 2'd0, 1, 1, 1'b1));
    repeat (PAGE_RUN) send_rect(rect(1'b0, 2'd0, 1, 1, 1'b1));
    send_rect(rect(1'b1, 2'd0, 1, 1, 1'b1));
    wait_placements();

    if (mismatches == 0) begin
      $display("block_aligned_shelf_atlas_packer verification clean");
    end else begin
      $display("block_aligned_shelf_atlas_packer verification failed");
    end
    $finish;
  end

endmodule
